[sv/fud_pkg.sv]
// fud_pkg: shared types, constants and helpers of the form body decoder
// used by every module of the decoder; depends on nothing

package fud_pkg;

    localparam int MAX_PAIRS = 32;
    localparam int C_CNT_W   = $clog2(MAX_PAIRS + 1);
    localparam int C_IDX_W   = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;

    localparam int C_QDEPTH  = 4;
    localparam int C_QPTR_W  = $clog2(C_QDEPTH);
    localparam int C_QCNT_W  = $clog2(C_QDEPTH + 1);

    localparam int C_APB_AW  = 3;
    localparam int C_APB_DW  = 32;
    localparam logic [0:0] C_REG_VALUE_LIMIT = 1'b0;
    localparam logic [7:0] C_VALUE_LIMIT_RST = 8'd64;

    localparam logic [7:0] C_AMP   = 8'h26;
    localparam logic [7:0] C_EQ    = 8'h3D;
    localparam logic [7:0] C_PLUS  = 8'h2B;
    localparam logic [7:0] C_PCT   = 8'h25;
    localparam logic [7:0] C_SPACE = 8'h20;
    localparam logic [4:0] C_NOT_HEX = 5'd16;

    localparam logic [4:0] C_DROP_IDX = 5'((MAX_PAIRS - 1) % 32);

    typedef enum logic [1:0] {
        K_KEY   = 2'd0,
        K_VALUE = 2'd1,
        K_END   = 2'd2
    } t_kind;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_body;
    } t_in_item;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] out_byte;
        logic [4:0] pair_index;
        logic       value_truncated;
        logic       pairs_dropped;
        logic       run_last;
    } t_out_item;

    // one queue entry holds every result of one input item
    typedef struct packed {
        logic      two;
        t_out_item r0;
        t_out_item r1;
    } t_qent;

    function automatic logic [4:0] f_hex(input logic [7:0] c);
        logic [4:0] d;
        if (c inside {[8'h30:8'h39]}) begin
            d = 5'(c - 8'h30);
        end else if (c inside {[8'h61:8'h66]}) begin
            d = 5'(c - 8'h57);
        end else if (c inside {[8'h41:8'h46]}) begin
            d = 5'(c - 8'h37);
        end else begin
            d = C_NOT_HEX;
        end
        return d;
    endfunction

    function automatic logic [4:0] f_pair_field(input logic [C_IDX_W-1:0] idx);
        logic [C_IDX_W+4:0] wide;
        wide = {5'b0, idx};
        return wide[4:0];
    endfunction

endpackage

[sv/fud_front.sv]
// fud_front: takes body bytes, tracks the pair parse and the escape decode
// pushes the results of each item as one entry; depends on fud_pkg

module fud_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  fud_pkg::t_in_item  i_in_item,
    input  logic [7:0]         i_value_limit,
    input  logic               i_full,
    output logic               o_push,
    output fud_pkg::t_qent     o_entry
);

    typedef enum logic [6:0] {
        PH_SEP    = 7'b0000001,
        PH_LEADEQ = 7'b0000010,
        PH_KEY    = 7'b0000100,
        PH_VALSEP = 7'b0001000,
        PH_VAL    = 7'b0010000,
        PH_TAIL   = 7'b0100000,
        PH_DROP   = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic [1:0] stage;
        logic [7:0] accum;
        logic       stopped;
        logic       vreq;
        logic [7:0] vbyte;
    } t_esc;

    // a value byte already decoded by this item is kept
    function automatic t_esc f_finish(input t_esc e);
        t_esc r;
        r         = e;
        r.vreq    = e.vreq || (e.stage != 2'd0);
        r.vbyte   = (e.stage != 2'd0) ? e.accum : e.vbyte;
        r.stage   = 2'd0;
        r.accum   = 8'd0;
        r.stopped = 1'b0;
        return r;
    endfunction

    function automatic t_esc f_decode(input t_esc e, input logic [7:0] c);
        t_esc       r;
        logic [4:0] d;
        r = e;
        d = fud_pkg::f_hex(c);
        if (e.stage == 2'd0) begin
            if (c == fud_pkg::C_PLUS) begin
                r.vreq  = 1'b1;
                r.vbyte = fud_pkg::C_SPACE;
            end else if (c == fud_pkg::C_PCT) begin
                r.stage   = 2'd1;
                r.accum   = 8'd0;
                r.stopped = 1'b0;
            end else begin
                r.vreq  = 1'b1;
                r.vbyte = c;
            end
        end else begin
            if (d != fud_pkg::C_NOT_HEX && !e.stopped) begin
                r.accum = {e.accum[3:0], d[3:0]};
            end else begin
                r.stopped = 1'b1;
            end
            if (e.stage == 2'd1) begin
                r.stage = 2'd2;
            end else begin
                r = f_finish(r);
            end
        end
        return r;
    endfunction

    t_phase                       r_phase, n_phase, v_phase;
    logic [1:0]                   r_stage, n_stage;
    logic [7:0]                   r_accum, n_accum;
    logic                         r_stopped, n_stopped;
    logic [fud_pkg::C_CNT_W-1:0]  r_pair_count, n_pair_count, v_pcount;
    logic [fud_pkg::C_IDX_W-1:0]  r_cur, n_cur, v_cur;
    logic [7:0]                   r_vlen, n_vlen, v_vlen;
    logic                         r_trunc, n_trunc, v_trunc;
    logic                         r_drop, n_drop, v_drop;

    t_esc                 v_esc;
    logic                 v_has_key, v_has_b, v_has_e, v_has_d, v_ep;
    logic [7:0]           c;
    logic                 last;
    logic                 accept;
    fud_pkg::t_out_item   res_b, res_e, res_d;

    assign c          = i_in_item.data_byte;
    assign last       = i_in_item.end_of_body;
    assign o_in_ready = !i_full;
    assign accept     = i_in_valid && !i_full;

    always_comb begin
        v_phase   = r_phase;
        v_pcount  = r_pair_count;
        v_cur     = r_cur;
        v_vlen    = r_vlen;
        v_trunc   = r_trunc;
        v_drop    = r_drop;
        v_esc     = '{stage: r_stage, accum: r_accum, stopped: r_stopped,
                      vreq: 1'b0, vbyte: 8'd0};
        v_has_key = 1'b0;
        v_has_b   = 1'b0;
        v_has_e   = 1'b0;
        v_has_d   = 1'b0;
        v_ep      = 1'b0;

        if (c == fud_pkg::C_AMP) begin
            if (r_phase == PH_DROP) begin
                v_phase = PH_SEP;
            end else if (r_phase != PH_SEP) begin
                if (r_phase == PH_VAL) begin
                    v_esc = f_finish(v_esc);
                end
                v_ep    = 1'b1;
                v_phase = PH_SEP;
            end
        end else begin
            case (r_phase)
                PH_SEP: begin
                    if (r_pair_count < fud_pkg::C_CNT_W'(fud_pkg::MAX_PAIRS)) begin
                        v_cur     = r_pair_count[fud_pkg::C_IDX_W-1:0];
                        v_pcount  = fud_pkg::C_CNT_W'(r_pair_count + 1'b1);
                        v_trunc   = 1'b0;
                        v_vlen    = 8'd0;
                        v_esc     = '0;
                        if (c == fud_pkg::C_EQ) begin
                            v_phase = PH_LEADEQ;
                        end else begin
                            v_phase   = PH_KEY;
                            v_has_key = 1'b1;
                        end
                    end else begin
                        v_drop  = 1'b1;
                        v_phase = PH_DROP;
                    end
                end
                PH_LEADEQ: begin
                    if (c != fud_pkg::C_EQ) begin
                        v_phase   = PH_KEY;
                        v_has_key = 1'b1;
                    end
                end
                PH_KEY: begin
                    if (c == fud_pkg::C_EQ) begin
                        v_phase = PH_VALSEP;
                    end else begin
                        v_has_key = 1'b1;
                    end
                end
                PH_VALSEP: begin
                    if (c != fud_pkg::C_EQ) begin
                        v_phase = PH_VAL;
                        v_esc   = f_decode(v_esc, c);
                    end
                end
                PH_VAL: begin
                    if (c == fud_pkg::C_EQ) begin
                        v_esc   = f_finish(v_esc);
                        v_phase = PH_TAIL;
                    end else begin
                        v_esc = f_decode(v_esc, c);
                    end
                end
                default: begin
                end
            endcase
        end

        // end of body closes an open kept pair
        if (last && v_phase != PH_SEP && v_phase != PH_DROP) begin
            if (v_phase == PH_VAL) begin
                v_esc = f_finish(v_esc);
            end
            v_ep    = 1'b1;
            v_phase = PH_SEP;
        end

        if (v_esc.vreq) begin
            if (v_vlen < i_value_limit) begin
                v_has_b = 1'b1;
                v_vlen  = 8'(v_vlen + 1'b1);
            end else begin
                v_trunc = 1'b1;
            end
        end
        v_has_b = v_has_b || v_has_key;
        v_has_e = v_ep;
        v_has_d = last && v_drop;

        res_b = '{kind: v_has_key ? fud_pkg::K_KEY : fud_pkg::K_VALUE,
                  out_byte: v_has_key ? c : v_esc.vbyte,
                  pair_index: fud_pkg::f_pair_field(v_cur),
                  value_truncated: 1'b0, pairs_dropped: 1'b0, run_last: 1'b0};
        res_e = '{kind: fud_pkg::K_END, out_byte: 8'd0,
                  pair_index: fud_pkg::f_pair_field(v_cur),
                  value_truncated: v_trunc, pairs_dropped: v_drop, run_last: 1'b0};
        res_d = '{kind: fud_pkg::K_END, out_byte: 8'd0,
                  pair_index: fud_pkg::C_DROP_IDX,
                  value_truncated: 1'b0, pairs_dropped: 1'b1, run_last: 1'b0};

        o_entry.two = (v_has_b && v_has_e) || (v_has_b && v_has_d) || (v_has_e && v_has_d);
        o_entry.r0  = v_has_b ? res_b : (v_has_e ? res_e : res_d);
        o_entry.r1  = v_has_b ? (v_has_e ? res_e : res_d) : res_d;
        o_entry.r0.run_last = !o_entry.two;
        o_entry.r1.run_last = 1'b1;

        if (last) begin
            n_phase      = PH_SEP;
            n_stage      = 2'd0;
            n_accum      = 8'd0;
            n_stopped    = 1'b0;
            n_pair_count = '0;
            n_cur        = '0;
            n_vlen       = 8'd0;
            n_trunc      = 1'b0;
            n_drop       = 1'b0;
        end else begin
            n_phase      = v_phase;
            n_stage      = v_esc.stage;
            n_accum      = v_esc.accum;
            n_stopped    = v_esc.stopped;
            n_pair_count = v_pcount;
            n_cur        = v_cur;
            n_vlen       = v_vlen;
            n_trunc      = v_trunc;
            n_drop       = v_drop;
        end
    end

    assign o_push = accept && (v_has_b || v_has_e || v_has_d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_SEP;
            r_stage      <= 2'd0;
            r_accum      <= 8'd0;
            r_stopped    <= 1'b0;
            r_pair_count <= '0;
            r_cur        <= '0;
            r_vlen       <= 8'd0;
            r_trunc      <= 1'b0;
            r_drop       <= 1'b0;
        end else if (accept) begin
            r_phase      <= n_phase;
            r_stage      <= n_stage;
            r_accum      <= n_accum;
            r_stopped    <= n_stopped;
            r_pair_count <= n_pair_count;
            r_cur        <= n_cur;
            r_vlen       <= n_vlen;
            r_trunc      <= n_trunc;
            r_drop       <= n_drop;
        end
    end

`ifndef SYNTHESIS
    a_body_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && last |=> r_phase == PH_SEP && r_pair_count == '0)
        else $error("state not cleared after end of body");

    a_drop_at_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DROP |-> r_pair_count == fud_pkg::C_CNT_W'(fud_pkg::MAX_PAIRS))
        else $error("dropping pairs below capacity");
`endif

endmodule

[sv/fud_queue.sv]
// fud_queue: short first-in first-out queue of result entries
// sits between the parser and the output stage; depends on fud_pkg

module fud_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  fud_pkg::t_qent i_entry,
    input  logic           i_pop,
    output fud_pkg::t_qent o_head,
    output logic           o_full,
    output logic           o_empty
);

    fud_pkg::t_qent                r_mem [fud_pkg::C_QDEPTH];
    logic [fud_pkg::C_QPTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [fud_pkg::C_QPTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [fud_pkg::C_QCNT_W-1:0]  r_count, n_count;

    assign o_full  = (r_count == fud_pkg::C_QCNT_W'(fud_pkg::C_QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == fud_pkg::C_QPTR_W'(fud_pkg::C_QDEPTH - 1)) ?
                       '0 : fud_pkg::C_QPTR_W'(r_wr_ptr + 1'b1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == fud_pkg::C_QPTR_W'(fud_pkg::C_QDEPTH - 1)) ?
                       '0 : fud_pkg::C_QPTR_W'(r_rd_ptr + 1'b1);
        end
        if (i_push && !i_pop) begin
            n_count = fud_pkg::C_QCNT_W'(r_count + 1'b1);
        end else if (i_pop && !i_push) begin
            n_count = fud_pkg::C_QCNT_W'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full || i_pop)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");
`endif

endmodule

[sv/fud_back.sv]
// fud_back: output stage, hands out the one or two results of each entry
// holds the result register of the output channel; depends on fud_pkg

module fud_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fud_pkg::t_qent      i_head,
    input  logic                i_empty,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output fud_pkg::t_out_item  o_out_item
);

    logic               r_valid;
    logic               r_sub;
    fud_pkg::t_out_item r_item;
    logic               load;

    assign load        = !i_empty && (!r_valid || i_out_ready);
    assign o_pop       = load && (r_sub || !i_head.two);
    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= r_sub ? i_head.r1 : i_head.r0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_sub   <= !r_sub && i_head.two;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_second_has_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sub |-> !i_empty && i_head.two)
        else $error("second result pending without its entry");
`endif

endmodule

[sv/form_urlencoded_decoder.sv]
// form_urlencoded_decoder: top level of the form body decoder
// parser front, result queue, output stage and the limit register
// depends on fud_pkg, fud_front, fud_queue, fud_back
//
// usage:
//   input channel: one body byte per item with an end-of-body mark
//   output channel: key bytes, decoded value bytes and end-of-pair items,
//   run_last set on the last item caused by one input byte
//   apb port: one register, value_limit at address 0, reset value 64
// path: an accepted input item's results pass the queue and the output register
// throughput: one input item per cycle while the queue is not full; an
//   item that causes two results holds the output until both are handed
//   out, one that causes none passes without touching it; the four-entry
//   queue between parser and output stage absorbs bursts of two-result items
// reset: synchronous, clears parse state, queue and output valid, sets value_limit to 64
// receiver stall: the output item holds, the queue fills, then in_ready
//   drops until an entry is popped from the queue

module form_urlencoded_decoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  fud_pkg::t_in_item             i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output fud_pkg::t_out_item            o_out_item,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fud_pkg::C_APB_AW-1:0]  paddr,
    input  logic [fud_pkg::C_APB_DW-1:0]  pwdata,
    output logic [fud_pkg::C_APB_DW-1:0]  prdata,
    output logic                          pready
);

    logic [7:0]      r_value_limit;
    logic            reg_hit;
    logic            push, pop, full, empty;
    fud_pkg::t_qent  entry, head;

    assign reg_hit = (paddr[fud_pkg::C_APB_AW-1:2] == fud_pkg::C_REG_VALUE_LIMIT);
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? fud_pkg::C_APB_DW'(r_value_limit) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value_limit <= fud_pkg::C_VALUE_LIMIT_RST;
        end else if (psel && penable && pwrite && reg_hit) begin
            r_value_limit <= pwdata[7:0];
        end
    end

    fud_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_item     (i_in_item),
        .i_value_limit (r_value_limit),
        .i_full        (full),
        .o_push        (push),
        .o_entry       (entry)
    );

    fud_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (full),
        .o_empty (empty)
    );

    fud_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule
